// ===== hw/rtl/indexed_min_heap_assert.svh =====
// assertion macros used by the heap sequencer rtl
// the enclosing module provides clk and arst_n
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IMH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/imh_pkg.sv =====
`timescale 1ns / 1ps

package imh_pkg;

	localparam int NODES   = 1024;
	localparam int ADDR_W  = $clog2(NODES);
	localparam int SIZE_W  = ADDR_W + 1;
	localparam int CHILD_W = ADDR_W + 2;
	localparam int KEY_W   = 32;
	localparam int NODE_W  = 10;
	localparam int ENT_W   = ADDR_W + KEY_W;

	localparam logic [SIZE_W-1:0] SIZE_FULL = SIZE_W'(NODES);

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_LOAD    = 3'd1;
	localparam logic [2:0] OP_BUILD   = 3'd2;
	localparam logic [2:0] OP_EXTRACT = 3'd3;
	localparam logic [2:0] OP_PEEK    = 3'd4;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [KEY_W-1:0] key_in;
	} in_t;

	typedef struct packed {
		logic [NODE_W-1:0]       node_id;
		logic signed [KEY_W-1:0] key_out;
		logic                    underflow;
		logic                    full_res;
	} out_t;

	// one heap slot: node tag and key
	typedef struct packed {
		logic [ADDR_W-1:0]       node;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	// sequencer request to the slot memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	// finished result handed to the output stage
	typedef struct packed {
		logic valid;
		out_t data;
	} res_beat_t;

endpackage

// ===== hw/rtl/imh_ram.sv =====
`timescale 1ns / 1ps

module imh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hw/rtl/imh_outbuf.sv =====
`timescale 1ns / 1ps

module imh_outbuf import imh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_beat_t push,
	output logic      can_take,
	output logic      out_valid,
	input  logic      out_ready,
	output out_t      out_data
);

	logic valid_q;
	out_t data_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid && can_take) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && can_take) begin
			data_q <= push.data;
		end
	end

endmodule

// ===== hw/rtl/imh_seq.sv =====
`timescale 1ns / 1ps
`include "indexed_min_heap_assert.svh"

module imh_seq import imh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_t       in_data,
	input  logic      can_take,
	output res_beat_t push,
	output mem_req_t  mem_req,
	input  entry_t    rd_a,
	input  entry_t    rd_b
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PEEK = 3'd1;
	localparam logic [2:0] S_EXT  = 3'd2;
	localparam logic [2:0] S_BLD  = 3'd3;
	localparam logic [2:0] S_SIFT = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic              bld_q, bld_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	entry_t            cur_q, cur_d;
	out_t              res_q, res_d;

	logic               fin;
	out_t               fin_res;
	logic [CHILD_W-1:0] lc, rc, best_c;
	logic               take_l, take_r;
	logic signed [KEY_W-1:0] best_key;
	logic               wait_stall;

	function automatic logic [CHILD_W-1:0] left_of(logic [ADDR_W-1:0] p);
		return {1'b0, p, 1'b1};
	endfunction

	function automatic logic [CHILD_W-1:0] right_of(logic [ADDR_W-1:0] p);
		return {1'b0, p, 1'b1} + CHILD_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] lc_of_idx(logic [ADDR_W-1:0] p);
		logic [CHILD_W-1:0] c;
		c = left_of(p);
		return c[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] rc_of_idx(logic [ADDR_W-1:0] p);
		logic [CHILD_W-1:0] c;
		c = right_of(p);
		return c[ADDR_W-1:0];
	endfunction

	// one sift level: children of pos_q were read last cycle
	assign lc       = left_of(pos_q);
	assign rc       = right_of(pos_q);
	assign take_l   = (lc < CHILD_W'(size_q)) && ($signed(rd_a.key) < $signed(cur_q.key));
	assign best_key = take_l ? rd_a.key : cur_q.key;
	assign take_r   = (rc < CHILD_W'(size_q)) && ($signed(rd_b.key) < $signed(best_key));
	assign best_c   = take_r ? rc : lc;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		size_d  = size_q;
		bld_d   = bld_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		cur_d   = cur_q;
		res_d   = res_q;
		mem_req = '0;
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.opcode)
						OP_CLEAR: begin
							size_d = '0;
							fin    = 1'b1;
						end
						OP_LOAD: begin
							if (size_q == SIZE_FULL) begin
								fin_res.full_res = 1'b1;
							end else begin
								mem_req.we         = 1'b1;
								mem_req.waddr      = size_q[ADDR_W-1:0];
								mem_req.wdata.node = size_q[ADDR_W-1:0];
								mem_req.wdata.key  = in_data.key_in;
								size_d             = size_q + SIZE_W'(1);
							end
							fin = 1'b1;
						end
						OP_BUILD: begin
							if (size_q == '0) begin
								fin = 1'b1;
							end else begin
								idx_d           = ADDR_W'(size_q >> 1);
								mem_req.raddr_a = idx_d;
								bld_d           = 1'b1;
								state_d         = S_BLD;
							end
						end
						OP_EXTRACT: begin
							if (size_q == '0) begin
								fin_res.underflow = 1'b1;
								fin               = 1'b1;
							end else begin
								mem_req.raddr_a = '0;
								mem_req.raddr_b = ADDR_W'(size_q - SIZE_W'(1));
								bld_d           = 1'b0;
								state_d         = S_EXT;
							end
						end
						OP_PEEK: begin
							if (size_q == '0) begin
								fin_res.underflow = 1'b1;
								fin               = 1'b1;
							end else begin
								mem_req.raddr_a = '0;
								state_d         = S_PEEK;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_PEEK: begin
				fin_res.key_out = rd_a.key;
				fin             = 1'b1;
			end
			S_EXT: begin
				// root leaves, last slot is carried down from the top
				res_d         = '0;
				res_d.node_id = NODE_W'(rd_a.node);
				res_d.key_out = rd_a.key;
				cur_d         = rd_b;
				size_d        = size_q - SIZE_W'(1);
				pos_d         = '0;
				if (size_q == SIZE_W'(1)) begin
					fin_res = res_d;
					fin     = 1'b1;
				end else begin
					mem_req.raddr_a = lc_of_idx('0);
					mem_req.raddr_b = rc_of_idx('0);
					state_d         = S_SIFT;
				end
			end
			S_BLD: begin
				cur_d           = rd_a;
				pos_d           = idx_q;
				mem_req.raddr_a = lc_of_idx(idx_q);
				mem_req.raddr_b = rc_of_idx(idx_q);
				state_d         = S_SIFT;
			end
			S_SIFT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				if (!take_l && !take_r) begin
					// carried entry settles here
					mem_req.wdata = cur_q;
					if (bld_q) begin
						if (idx_q == '0) begin
							fin = 1'b1;
						end else begin
							idx_d           = idx_q - ADDR_W'(1);
							mem_req.raddr_a = idx_d;
							state_d         = S_BLD;
						end
					end else begin
						fin_res = res_q;
						fin     = 1'b1;
					end
				end else begin
					// smaller child moves up, keep going one level down
					mem_req.wdata   = take_r ? rd_b : rd_a;
					pos_d           = best_c[ADDR_W-1:0];
					mem_req.raddr_a = lc_of_idx(pos_d);
					mem_req.raddr_b = rc_of_idx(pos_d);
				end
			end
			S_WAIT: begin
				fin_res = res_q;
				fin     = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			if (can_take) begin
				state_d = S_IDLE;
			end else begin
				state_d = S_WAIT;
				res_d   = fin_res;
			end
		end
	end

	assign push.valid = fin && can_take;
	assign push.data  = fin_res;

	assign wait_stall = (state_q == S_WAIT) && !can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= '0;
			bld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
			bld_q   <= bld_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		idx_q <= idx_d;
		cur_q <= cur_d;
		res_q <= res_d;
	end

	`IMH_ASSERT_NOW(a_size_bound, 1'b1, size_q <= SIZE_FULL, "heap size beyond store depth")
	`IMH_ASSERT_NOW(a_sift_pos, state_q == S_SIFT, SIZE_W'(pos_q) < size_q, "sift outside heap")
	`IMH_ASSERT_NEXT(a_wait_hold, wait_stall, state_q == S_WAIT && $stable(res_q), "result lost")

endmodule

// ===== hw/rtl/indexed_min_heap.sv =====
`timescale 1ns / 1ps
// channel | signals                        | beat
// --------+--------------------------------+---------------------------------------
// in      | in_valid, in_ready, in_data    | one operation: opcode and load key
// out     | out_valid, out_ready, out_data | one result per operation
//
// load, clear and unused opcodes finish straight from idle; peek reads the root, then returns
// its key; extract reads root and last slot and returns at once when it takes the last entry,
// else sifts the carried entry down one level per read-compare-write step on the two-read-port
// slot memory (at most log2 of the depth levels); build sifts each index from size/2 down to 0
// arst_n clears the heap size and the handshake state; slot memory contents are not reset
// an operation is taken while an earlier result still waits; a finished result that
// finds the output register full parks until out_ready, holding off in_ready

module indexed_min_heap import imh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	// slot memory: node tag and key per heap position
	mem_req_t   mem_req;
	logic [ENT_W-1:0] ram_rd_a;
	logic [ENT_W-1:0] ram_rd_b;
	entry_t     rd_a;
	entry_t     rd_b;

	// result path from sequencer to output register
	res_beat_t  push;
	logic       can_take;

	assign rd_a = entry_t'(ram_rd_a);
	assign rd_b = entry_t'(ram_rd_b);

	imh_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NODES)
	) u_ram (
		.clk     (clk),
		.we      (mem_req.we),
		.waddr   (mem_req.waddr),
		.wdata   (mem_req.wdata),
		.raddr_a (mem_req.raddr_a),
		.rdata_a (ram_rd_a),
		.raddr_b (mem_req.raddr_b),
		.rdata_b (ram_rd_b)
	);

	// operation sequencer: load, build, extract and peek over the slot memory
	imh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.can_take (can_take),
		.push     (push),
		.mem_req  (mem_req),
		.rd_a     (rd_a),
		.rd_b     (rd_b)
	);

	// output register decouples the result side from the sequencer
	imh_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
